[rtl/rbb3_pkg.sv]
// Shared constants, register indexes and pipeline types of the 3x3 RGB box blur.
package rbb3_pkg;

  localparam int MAX_WIDTH  = 1024;
  localparam int MAX_HEIGHT = 4096;

  localparam int CH_W   = 8;
  localparam int PIX_W  = 3 * CH_W;
  localparam int COL_W  = $clog2(MAX_WIDTH);
  localparam int WID_W  = COL_W + 1;
  localparam int ROW_W  = $clog2(MAX_HEIGHT) + 1;
  localparam int FW_W   = 11;
  localparam int FH_W   = 13;
  localparam int LINE_W = 2 * PIX_W;

  localparam int CFG_IDX_W  = 8;
  localparam int CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = CFG_IDX_W'(1);

  localparam logic [FW_W-1:0] FRAME_WIDTH_RST  = FW_W'(640);
  localparam logic [FH_W-1:0] FRAME_HEIGHT_RST = FH_W'(480);

  localparam logic KIND_PIXEL = 1'b0;
  localparam logic KIND_DRAIN = 1'b1;

  // Nine 8-bit values sum to at most 2295.
  localparam int SUM_W = 12;

  // x / 9 == (x * 3641) >> 15 for every x up to 2295.
  localparam int RECIP_W  = 12;
  localparam int RECIP_SH = 15;
  localparam logic [RECIP_W-1:0] RECIP_NINE = RECIP_W'(3641);
  localparam int PROD_W = SUM_W + RECIP_W;

  // Item held between the accept register and the window.
  typedef struct packed {
    logic             due;
    logic             interior;
    logic             fend;
    logic             byp;
    logic [COL_W-1:0] col;
    logic [PIX_W-1:0] pix;
  } rbb3_item_t;

  // Item held between the window sums and the divide stage.
  typedef struct packed {
    logic [SUM_W-1:0] acc_red;
    logic [SUM_W-1:0] acc_green;
    logic [SUM_W-1:0] acc_blue;
    logic [PIX_W-1:0] centre;
    logic             interior;
    logic             fend;
  } rbb3_sum_t;

endpackage

[rtl/rbb3_if.sv]
// Handshake channels of the box blur: pixel input, result output and register writes.
interface rbb3_in_if;
  logic                  valid;
  logic                  ready;
  logic                  kind;
  logic [rbb3_pkg::CH_W-1:0] red;
  logic [rbb3_pkg::CH_W-1:0] green;
  logic [rbb3_pkg::CH_W-1:0] blue;

  modport source (output valid, kind, red, green, blue, input ready);
  modport sink   (input valid, kind, red, green, blue, output ready);
endinterface

interface rbb3_out_if;
  logic                  valid;
  logic                  ready;
  logic [rbb3_pkg::CH_W-1:0] out_red;
  logic [rbb3_pkg::CH_W-1:0] out_green;
  logic [rbb3_pkg::CH_W-1:0] out_blue;
  logic                  frame_end;

  modport source (output valid, out_red, out_green, out_blue, frame_end, input ready);
  modport sink   (input valid, out_red, out_green, out_blue, frame_end, output ready);
endinterface

interface rbb3_cfg_if;
  logic                            valid;
  logic                            ready;
  logic [rbb3_pkg::CFG_IDX_W-1:0]  index;
  logic [rbb3_pkg::CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

[rtl/rbb3_ram.sv]
// Generic single-port-write, single-port-read RAM with registered read data.
module rbb3_ram #(
  parameter int WIDTH = 48,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem_r[rd_addr];
    end
  end

endmodule

[rtl/rbb3_ctrl.sv]
// Register file, frame position counters and the accept register of the box blur.
module rbb3_ctrl (
  input  logic                      clk,
  input  logic                      rst_n,
  rbb3_in_if.sink                   in_pix,
  rbb3_cfg_if.sink                  cfg_wr,
  input  logic                      adv,
  output logic                      rd_en,
  output logic [rbb3_pkg::COL_W-1:0] rd_addr,
  output logic                      s0_valid_r,
  output rbb3_pkg::rbb3_item_t      s0_r
);

  logic [rbb3_pkg::FW_W-1:0]  fw_r;
  logic [rbb3_pkg::FH_W-1:0]  fh_r;
  logic [rbb3_pkg::COL_W-1:0] in_col_r, in_col_nxt;
  logic [rbb3_pkg::ROW_W-1:0] in_row_r, in_row_nxt;
  logic [rbb3_pkg::COL_W-1:0] out_col_r, out_col_nxt;
  logic [rbb3_pkg::ROW_W-1:0] out_row_r, out_row_nxt;

  logic [rbb3_pkg::WID_W-1:0] w_eff;
  logic [rbb3_pkg::ROW_W-1:0] h_eff;
  logic cfg_acc, cfg_hit;
  logic live, take, due, interior, fend;
  logic in_col_last, out_col_last, out_row_last;
  logic [rbb3_pkg::WID_W-1:0] in_col_inc, out_col_inc;
  logic [rbb3_pkg::ROW_W-1:0] out_row_inc;
  logic [rbb3_pkg::PIX_W-1:0] pix;

  assign cfg_wr.ready = 1'b1;
  assign cfg_acc      = cfg_wr.valid;
  assign cfg_hit      = cfg_acc && (cfg_wr.index == rbb3_pkg::REG_FRAME_WIDTH ||
                                    cfg_wr.index == rbb3_pkg::REG_FRAME_HEIGHT);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fw_r <= rbb3_pkg::FRAME_WIDTH_RST;
      fh_r <= rbb3_pkg::FRAME_HEIGHT_RST;
    end else if (cfg_acc) begin
      unique case (cfg_wr.index)
        rbb3_pkg::REG_FRAME_WIDTH:  fw_r <= cfg_wr.data[rbb3_pkg::FW_W-1:0];
        rbb3_pkg::REG_FRAME_HEIGHT: fh_r <= cfg_wr.data[rbb3_pkg::FH_W-1:0];
        default: ;
      endcase
    end
  end

  // Clamp zero to one and large values to the line and frame limits.
  always_comb begin
    if (fw_r == '0) begin
      w_eff = rbb3_pkg::WID_W'(1);
    end else if (fw_r > rbb3_pkg::FW_W'(rbb3_pkg::MAX_WIDTH)) begin
      w_eff = rbb3_pkg::WID_W'(rbb3_pkg::MAX_WIDTH);
    end else begin
      w_eff = rbb3_pkg::WID_W'(fw_r);
    end
    if (fh_r == '0) begin
      h_eff = rbb3_pkg::ROW_W'(1);
    end else if (fh_r > rbb3_pkg::FH_W'(rbb3_pkg::MAX_HEIGHT)) begin
      h_eff = rbb3_pkg::ROW_W'(rbb3_pkg::MAX_HEIGHT);
    end else begin
      h_eff = rbb3_pkg::ROW_W'(fh_r);
    end
  end

  assign in_pix.ready = adv;

  // Drop drain ticks while the frame still expects pixels.
  assign live = in_row_r < h_eff;
  assign take = in_pix.valid && adv && (!live || in_pix.kind == rbb3_pkg::KIND_PIXEL);
  assign pix  = live ? {in_pix.red, in_pix.green, in_pix.blue} : '0;

  assign in_col_inc   = rbb3_pkg::WID_W'(in_col_r) + rbb3_pkg::WID_W'(1);
  assign out_col_inc  = rbb3_pkg::WID_W'(out_col_r) + rbb3_pkg::WID_W'(1);
  assign out_row_inc  = out_row_r + rbb3_pkg::ROW_W'(1);
  assign in_col_last  = in_col_inc >= w_eff;
  assign out_col_last = out_col_inc >= w_eff;
  assign out_row_last = out_row_inc >= h_eff;

  assign due = (in_row_r >= rbb3_pkg::ROW_W'(2)) ||
               (in_row_r == rbb3_pkg::ROW_W'(1) && in_col_r != '0);
  assign interior = (w_eff >= rbb3_pkg::WID_W'(3)) && (h_eff >= rbb3_pkg::ROW_W'(3)) &&
                    (out_row_r != '0) && !out_row_last &&
                    (out_col_r != '0) && !out_col_last;
  assign fend = out_row_last && out_col_last;

  always_comb begin
    in_col_nxt  = in_col_r;
    in_row_nxt  = in_row_r;
    out_col_nxt = out_col_r;
    out_row_nxt = out_row_r;
    if (cfg_hit) begin
      in_col_nxt  = '0;
      in_row_nxt  = '0;
      out_col_nxt = '0;
      out_row_nxt = '0;
    end else if (take) begin
      if (in_col_last) begin
        in_col_nxt = '0;
        in_row_nxt = in_row_r + rbb3_pkg::ROW_W'(1);
      end else begin
        in_col_nxt = in_col_inc[rbb3_pkg::COL_W-1:0];
      end
      if (due) begin
        if (fend) begin
          in_col_nxt  = '0;
          in_row_nxt  = '0;
          out_col_nxt = '0;
          out_row_nxt = '0;
        end else if (out_col_last) begin
          out_col_nxt = '0;
          out_row_nxt = out_row_inc;
        end else begin
          out_col_nxt = out_col_inc[rbb3_pkg::COL_W-1:0];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_col_r   <= '0;
      in_row_r   <= '0;
      out_col_r  <= '0;
      out_row_r  <= '0;
      s0_valid_r <= 1'b0;
    end else begin
      in_col_r  <= in_col_nxt;
      in_row_r  <= in_row_nxt;
      out_col_r <= out_col_nxt;
      out_row_r <= out_row_nxt;
      if (adv) begin
        s0_valid_r <= take;
      end
    end
  end

  // The item leaving the accept register writes the column this one reads: flag it.
  always_ff @(posedge clk) begin
    if (take) begin
      s0_r.due      <= due;
      s0_r.interior <= interior;
      s0_r.fend     <= fend;
      s0_r.byp      <= s0_valid_r && (s0_r.col == in_col_r);
      s0_r.col      <= in_col_r;
      s0_r.pix      <= pix;
    end
  end

  assign rd_en   = take;
  assign rd_addr = in_col_r;

endmodule

[rtl/rbb3_window.sv]
// 3x3 window of cells, line store write-back and per-channel neighbourhood sums.
module rbb3_window (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        adv,
  input  logic                        s0_valid,
  input  rbb3_pkg::rbb3_item_t        s0,
  input  logic [rbb3_pkg::LINE_W-1:0] rd_data,
  output logic                        wr_en,
  output logic [rbb3_pkg::COL_W-1:0]  wr_addr,
  output logic [rbb3_pkg::LINE_W-1:0] wr_data,
  output logic                        s2_valid_r,
  output rbb3_pkg::rbb3_sum_t         s2_r
);

  logic [rbb3_pkg::PIX_W-1:0]  win_r [3][3];
  logic [rbb3_pkg::LINE_W-1:0] byp_r;
  logic [rbb3_pkg::LINE_W-1:0] line_rd;
  logic [rbb3_pkg::PIX_W-1:0]  upper, middle;
  logic                        shift_en;
  logic                        s1_valid_r, s1_interior_r, s1_fend_r;
  logic [rbb3_pkg::SUM_W-1:0]  acc_red, acc_green, acc_blue;

  assign line_rd  = s0.byp ? byp_r : rd_data;
  assign upper    = line_rd[rbb3_pkg::LINE_W-1:rbb3_pkg::PIX_W];
  assign middle   = line_rd[rbb3_pkg::PIX_W-1:0];
  assign shift_en = adv && s0_valid;

  // Middle line moves up, the new pixel becomes the middle line.
  assign wr_en   = shift_en;
  assign wr_addr = s0.col;
  assign wr_data = {middle, s0.pix};

  always_ff @(posedge clk) begin
    if (shift_en) begin
      byp_r <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int r = 0; r < 3; r++) begin
        for (int c = 0; c < 3; c++) begin
          win_r[r][c] <= '0;
        end
      end
    end else if (shift_en) begin
      for (int r = 0; r < 3; r++) begin
        win_r[r][0] <= win_r[r][1];
        win_r[r][1] <= win_r[r][2];
      end
      win_r[0][2] <= upper;
      win_r[1][2] <= middle;
      win_r[2][2] <= s0.pix;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      s2_valid_r <= 1'b0;
    end else if (adv) begin
      s1_valid_r <= s0_valid && s0.due;
      s2_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (shift_en) begin
      s1_interior_r <= s0.interior;
      s1_fend_r     <= s0.fend;
    end
  end

  always_comb begin
    acc_red   = '0;
    acc_green = '0;
    acc_blue  = '0;
    for (int r = 0; r < 3; r++) begin
      for (int c = 0; c < 3; c++) begin
        acc_red   = acc_red   + rbb3_pkg::SUM_W'(win_r[r][c][23:16]);
        acc_green = acc_green + rbb3_pkg::SUM_W'(win_r[r][c][15:8]);
        acc_blue  = acc_blue  + rbb3_pkg::SUM_W'(win_r[r][c][7:0]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s2_r.acc_red   <= acc_red;
      s2_r.acc_green <= acc_green;
      s2_r.acc_blue  <= acc_blue;
      s2_r.centre    <= win_r[1][1];
      s2_r.interior  <= s1_interior_r;
      s2_r.fend      <= s1_fend_r;
    end
  end

endmodule

[rtl/rbb3_out.sv]
// Divide-by-nine stage and result register with the output handshake.
module rbb3_out (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                s2_valid,
  input  rbb3_pkg::rbb3_sum_t s2,
  rbb3_out_if.source          out_res,
  output logic                adv
);

  logic [rbb3_pkg::PROD_W-1:0] prod_red, prod_green, prod_blue;
  logic [rbb3_pkg::PIX_W-1:0]  result;
  logic                        out_valid_r, out_fend_r;
  logic [rbb3_pkg::PIX_W-1:0]  out_pix_r;

  assign prod_red   = rbb3_pkg::PROD_W'(s2.acc_red)   * rbb3_pkg::PROD_W'(rbb3_pkg::RECIP_NINE);
  assign prod_green = rbb3_pkg::PROD_W'(s2.acc_green) * rbb3_pkg::PROD_W'(rbb3_pkg::RECIP_NINE);
  assign prod_blue  = rbb3_pkg::PROD_W'(s2.acc_blue)  * rbb3_pkg::PROD_W'(rbb3_pkg::RECIP_NINE);

  // Border pixels pass the centre through.
  assign result = s2.interior ?
    {prod_red[rbb3_pkg::RECIP_SH+rbb3_pkg::CH_W-1:rbb3_pkg::RECIP_SH],
     prod_green[rbb3_pkg::RECIP_SH+rbb3_pkg::CH_W-1:rbb3_pkg::RECIP_SH],
     prod_blue[rbb3_pkg::RECIP_SH+rbb3_pkg::CH_W-1:rbb3_pkg::RECIP_SH]} : s2.centre;

  assign adv = !out_valid_r || out_res.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= s2_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && s2_valid) begin
      out_pix_r  <= result;
      out_fend_r <= s2.fend;
    end
  end

  assign out_res.valid     = out_valid_r;
  assign out_res.out_red   = out_pix_r[23:16];
  assign out_res.out_green = out_pix_r[15:8];
  assign out_res.out_blue  = out_pix_r[7:0];
  assign out_res.frame_end = out_fend_r;

endmodule

[rtl/rgb_box_blur_3x3_core.sv]
// The item that completes a window passes the window, sum and result registers before its result leaves.
// Throughput: one item per cycle while adv is high; the line store RAM takes one read and one write each cycle.
// Results trail the input stream by frame_width+1 items; drain ticks push out the tail.
// Reset (rst_n low, synchronous): registers to 640x480, counters, window and valids cleared.
// Line store contents are left as they are after reset and need no clearing pass.
module rgb_box_blur_3x3_core (
  input  logic        clk,
  input  logic        rst_n,
  rbb3_in_if.sink     in_pix,
  rbb3_out_if.source  out_res,
  rbb3_cfg_if.sink    cfg_wr
);

  // Pipeline: accept register (line store read issued) -> window shift and line
  // write-back -> sum register -> divide and result register. All stages move
  // together on adv, which is high whenever the result register is free or drained.

  logic                          adv;
  logic                          rd_en;
  logic [rbb3_pkg::COL_W-1:0]    rd_addr;
  logic [rbb3_pkg::LINE_W-1:0]   rd_data;
  logic                          wr_en;
  logic [rbb3_pkg::COL_W-1:0]    wr_addr;
  logic [rbb3_pkg::LINE_W-1:0]   wr_data;
  logic                          s0_valid;
  rbb3_pkg::rbb3_item_t          s0;
  logic                          s2_valid;
  rbb3_pkg::rbb3_sum_t           s2;

  // Counters, register file and the accept register; every position decision
  // (due, interior, frame end) is taken here when the item is accepted.
  rbb3_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_pix     (in_pix),
    .cfg_wr     (cfg_wr),
    .adv        (adv),
    .rd_en      (rd_en),
    .rd_addr    (rd_addr),
    .s0_valid_r (s0_valid),
    .s0_r       (s0)
  );

  // Both line stores share one RAM word per column: upper line high, middle line low.
  rbb3_ram #(
    .WIDTH (rbb3_pkg::LINE_W),
    .DEPTH (rbb3_pkg::MAX_WIDTH)
  ) u_line_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  // Window shift and write-back; a read that meets the write of the same column
  // (one-pixel-wide frames) takes the written word from a bypass register.
  rbb3_window u_window (
    .clk        (clk),
    .rst_n      (rst_n),
    .adv        (adv),
    .s0_valid   (s0_valid),
    .s0         (s0),
    .rd_data    (rd_data),
    .wr_en      (wr_en),
    .wr_addr    (wr_addr),
    .wr_data    (wr_data),
    .s2_valid_r (s2_valid),
    .s2_r       (s2)
  );

  // Divide by nine through a reciprocal multiply, then hold the result until taken.
  rbb3_out u_out (
    .clk      (clk),
    .rst_n    (rst_n),
    .s2_valid (s2_valid),
    .s2       (s2),
    .out_res  (out_res),
    .adv      (adv)
  );

`ifndef SYNTH
  // A read that collides with the concurrent write must be marked for bypass.
  a_bypass_flag: assert property (@(posedge clk) disable iff (!rst_n)
    (rd_en && wr_en && rd_addr == wr_addr) |=> s0.byp)
    else $error("line store collision not marked for bypass");

  // A stalled result blocks new input.
  a_stall_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
    (out_res.valid && !out_res.ready) |-> !in_pix.ready)
    else $error("input accepted while result stalled");

  // A pending sum is held while the pipeline stalls.
  a_sum_held: assert property (@(posedge clk) disable iff (!rst_n)
    (s2_valid && !adv) |=> s2_valid)
    else $error("pending sum lost during stall");
`endif

endmodule

[tb/tb_rgb_box_blur_3x3_core.sv]
// Self-checking bench for the 3x3 RGB box blur core: directed and random frames against an own blur predictor.
module tb_rgb_box_blur_3x3_core;
  import rbb3_pkg::*;

  // Divisor of the neighbourhood sum.
  localparam int unsigned BOX_AREA = 9;
  // Far above the slowest legal run (about 2.5k items, at most one result each, long stalls).
  localparam int unsigned CYCLE_LIMIT = 1_000_000;
  // A result trails its item through the window, sum and result registers; allow a margin before any register write.
  localparam int unsigned SETTLE_CYCLES = 12;
  localparam int unsigned RANDOM_ITEMS = 600;
  // No register lives at this index; writes to it must change nothing.
  localparam logic [CFG_IDX_W-1:0] REG_UNMAPPED = '1;

  typedef struct packed {
    logic [CH_W-1:0] red;
    logic [CH_W-1:0] green;
    logic [CH_W-1:0] blue;
    logic            frame_end;
  } blur_px_t;

  // Tracks the frame geometry and neighbourhood, and holds the blurred pixels still owed.
  class box_blur_tracker;
    logic [PIX_W-1:0] upper_line [MAX_WIDTH];
    logic [PIX_W-1:0] middle_line [MAX_WIDTH];
    logic [PIX_W-1:0] window [3][3];
    int unsigned      in_col, in_row, out_col, out_row;
    logic [FW_W-1:0]  width_reg;
    logic [FH_W-1:0]  height_reg;
    blur_px_t         blurred_q[$];
    int unsigned      mismatches;

    function new();
      foreach (upper_line[i]) begin
        upper_line[i] = '0;
        middle_line[i] = '0;
      end
      foreach (window[i, j]) window[i][j] = '0;
      width_reg = FRAME_WIDTH_RST;
      height_reg = FRAME_HEIGHT_RST;
      mismatches = 0;
      restart_frame();
    endfunction

    function void restart_frame();
      in_col = 0;
      in_row = 0;
      out_col = 0;
      out_row = 0;
    endfunction

    function int unsigned eff_width();
      if (width_reg == 0) return 1;
      if (width_reg > MAX_WIDTH) return MAX_WIDTH;
      return width_reg;
    endfunction

    function int unsigned eff_height();
      if (height_reg == 0) return 1;
      if (height_reg > MAX_HEIGHT) return MAX_HEIGHT;
      return height_reg;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      if (idx == REG_FRAME_WIDTH) begin
        width_reg = data[FW_W-1:0];
        restart_frame();
      end else if (idx == REG_FRAME_HEIGHT) begin
        height_reg = data[FH_W-1:0];
        restart_frame();
      end
    endfunction

    function void note_item(logic kind, logic [CH_W-1:0] red_in, green_in, blue_in);
      int unsigned w, h, col, sum_r, sum_g, sum_b, i, j;
      logic [PIX_W-1:0] pix, centre;
      logic due;
      blur_px_t px;
      w = eff_width();
      h = eff_height();
      pix = '0;
      // Drain ticks mean nothing until every pixel of the frame is in; after that any
      // item pushes the tail and its colour is dropped.
      if (in_row < h) begin
        if (kind == KIND_DRAIN) return;
        pix = {red_in, green_in, blue_in};
      end
      col = (in_col >= MAX_WIDTH) ? MAX_WIDTH - 1 : in_col;
      for (i = 0; i < 3; i++) begin
        window[i][0] = window[i][1];
        window[i][1] = window[i][2];
      end
      window[0][2] = upper_line[col];
      window[1][2] = middle_line[col];
      window[2][2] = pix;
      upper_line[col] = middle_line[col];
      middle_line[col] = pix;

      due = (in_row >= 2) || (in_row == 1 && in_col >= 1);
      in_col++;
      if (in_col >= w) begin
        in_col = 0;
        in_row++;
      end
      if (!due) return;

      centre = window[1][1];
      px.red = centre[2*CH_W +: CH_W];
      px.green = centre[CH_W +: CH_W];
      px.blue = centre[0 +: CH_W];
      if (w >= 3 && h >= 3 && out_row >= 1 && out_row + 1 < h
          && out_col >= 1 && out_col + 1 < w) begin
        sum_r = 0;
        sum_g = 0;
        sum_b = 0;
        for (i = 0; i < 3; i++) begin
          for (j = 0; j < 3; j++) begin
            sum_r += window[i][j][2*CH_W +: CH_W];
            sum_g += window[i][j][CH_W +: CH_W];
            sum_b += window[i][j][0 +: CH_W];
          end
        end
        px.red = CH_W'(sum_r / BOX_AREA);
        px.green = CH_W'(sum_g / BOX_AREA);
        px.blue = CH_W'(sum_b / BOX_AREA);
      end
      if (out_row + 1 >= h && out_col + 1 >= w) begin
        px.frame_end = 1'b1;
        restart_frame();
      end else begin
        px.frame_end = 1'b0;
        out_col++;
        if (out_col >= w) begin
          out_col = 0;
          out_row++;
        end
      end
      blurred_q.push_back(px);
    endfunction

    function void check_blurred(logic [CH_W-1:0] red, green, blue, logic fend);
      blur_px_t want;
      if (blurred_q.size() == 0) begin
        $error("result with nothing outstanding: red %0d green %0d blue %0d frame_end %0b",
               red, green, blue, fend);
        mismatches++;
        return;
      end
      want = blurred_q.pop_front();
      if (red !== want.red) begin
        $error("out_red: expected %0d, actual %0d", want.red, red);
        mismatches++;
      end
      if (green !== want.green) begin
        $error("out_green: expected %0d, actual %0d", want.green, green);
        mismatches++;
      end
      if (blue !== want.blue) begin
        $error("out_blue: expected %0d, actual %0d", want.blue, blue);
        mismatches++;
      end
      if (fend !== want.frame_end) begin
        $error("frame_end: expected %0b, actual %0b", want.frame_end, fend);
        mismatches++;
      end
    endfunction
  endclass

  logic clk;
  logic rst_n;

  rbb3_in_if  in_pix();
  rbb3_out_if out_res();
  rbb3_cfg_if cfg_wr();

  rgb_box_blur_3x3_core uut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_pix  (in_pix),
    .out_res (out_res),
    .cfg_wr  (cfg_wr)
  );

  box_blur_tracker tracker = new();

  // Percentages of cycles in which the sender holds back and the receiver stalls.
  int unsigned src_idle_pct;
  int unsigned sink_idle_pct;
  // Well-formed items sent during the random part; decides when it stops.
  int unsigned stream_items;
  int unsigned cycle_count;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Receiver: stall at random, one fresh decision per cycle.
  initial begin
    out_res.ready <= 1'b0;
    forever begin
      @(posedge clk);
      out_res.ready <= ($urandom_range(0, 99) >= sink_idle_pct);
    end
  end

  // Check every accepted result against the oldest outstanding blurred pixel.
  initial begin
    forever begin
      @(posedge clk);
      if (rst_n === 1'b1 && out_res.valid === 1'b1 && out_res.ready === 1'b1) begin
        tracker.check_blurred(out_res.out_red, out_res.out_green, out_res.out_blue,
                              out_res.frame_end);
      end
    end
  end

  // Watchdog: a hung core ends the run here.
  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $error("run exceeded %0d cycles", CYCLE_LIMIT);
    $display("FAIL");
    $finish;
  end

  function automatic logic [CH_W-1:0] pick_level();
    // Lean on the channel extremes now and then; they decide the sum range.
    case ($urandom_range(0, 9))
      0: return '0;
      1: return '1;
      default: return CH_W'($urandom_range(0, 255));
    endcase
  endfunction

  // Offer one item after a random hold-off and return at the edge that accepts it.
  // Valid stays high so that the next item can follow without a gap.
  task automatic push_item(input logic kind, input logic [CH_W-1:0] red, green, blue);
    while ($urandom_range(0, 99) < src_idle_pct) begin
      in_pix.valid <= 1'b0;
      @(posedge clk);
    end
    in_pix.valid <= 1'b1;
    in_pix.kind <= kind;
    in_pix.red <= red;
    in_pix.green <= green;
    in_pix.blue <= blue;
    do @(posedge clk); while (in_pix.ready !== 1'b1);
    tracker.note_item(kind, red, green, blue);
  endtask

  // Hold the input until every outstanding blurred pixel has come out.
  task automatic hold_until_caught_up();
    in_pix.valid <= 1'b0;
    while (tracker.blurred_q.size() != 0) @(posedge clk);
  endtask

  // Leave the core idle: nothing owed and no item left in the pipeline.
  task automatic quiesce();
    hold_until_caught_up();
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] data);
    quiesce();
    cfg_wr.valid <= 1'b1;
    cfg_wr.index <= idx;
    cfg_wr.data <= data;
    do @(posedge clk); while (cfg_wr.ready !== 1'b1);
    tracker.write_reg(idx, data);
    cfg_wr.valid <= 1'b0;
  endtask

  // Write both geometry registers; the bits above each register carry random junk.
  task automatic set_frame(input logic [FW_W-1:0] cols, input logic [FH_W-1:0] rows);
    logic [CFG_DATA_W-1:0] data;
    data = CFG_DATA_W'($urandom);
    data[FW_W-1:0] = cols;
    write_reg(REG_FRAME_WIDTH, data);
    data = CFG_DATA_W'($urandom);
    data[FH_W-1:0] = rows;
    write_reg(REG_FRAME_HEIGHT, data);
  endtask

  // Send one frame of random pixels and its drain tail. A noisy frame carries drain
  // ticks among its pixels (dropped by the core) and pixels in its tail (taken as drain).
  // A truncated frame stops part way, leaving the next register write to restart it.
  task automatic send_frame(input int unsigned cols, input int unsigned rows,
                            input bit noisy, input bit truncated);
    int unsigned pixels, last, k;
    pixels = cols * rows;
    last = truncated ? $urandom_range(0, pixels - 1) : pixels;
    for (k = 0; k < last; k++) begin
      if (noisy && $urandom_range(0, 19) == 0)
        push_item(KIND_DRAIN, pick_level(), pick_level(), pick_level());
      if (k == last / 2 && $urandom_range(0, 19) == 0)
        hold_until_caught_up();
      push_item(KIND_PIXEL, pick_level(), pick_level(), pick_level());
      stream_items++;
    end
    if (truncated) return;
    for (k = 0; k <= cols; k++) begin
      if (noisy && $urandom_range(0, 4) == 0)
        push_item(KIND_PIXEL, pick_level(), pick_level(), pick_level());
      else
        push_item(KIND_DRAIN, pick_level(), pick_level(), pick_level());
      stream_items++;
    end
    // A spare drain tick now falls at the head of the next frame and must be dropped.
    if (noisy && $urandom_range(0, 1) == 0)
      push_item(KIND_DRAIN, pick_level(), pick_level(), pick_level());
  endtask

  initial begin
    int unsigned cols, rows, frames, f, k;
    bit broken;

    // Drive every input to a known level before the first edge.
    rst_n <= 1'b0;
    in_pix.valid <= 1'b0;
    in_pix.kind <= KIND_PIXEL;
    in_pix.red <= '0;
    in_pix.green <= '0;
    in_pix.blue <= '0;
    cfg_wr.valid <= 1'b0;
    cfg_wr.index <= REG_FRAME_WIDTH;
    cfg_wr.data <= '0;
    src_idle_pct = 6;
    sink_idle_pct = 84;
    stream_items = 0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset geometry (640 wide): one row and a few pixels bring out the first top-row
    // results; the following register write cuts the frame short.
    for (k = 0; k < 640 + 5; k++)
      push_item(KIND_PIXEL, pick_level(), pick_level(), pick_level());

    // Directed: a 3x3 frame of full-scale pixels, so the interior sum hits its maximum,
    // led by a drain tick that arrives too early and must be dropped.
    set_frame(FW_W'(3), FH_W'(3));
    push_item(KIND_DRAIN, '1, '1, '1);
    repeat (9) push_item(KIND_PIXEL, '1, '1, '1);
    repeat (4) push_item(KIND_DRAIN, '0, '0, '0);

    // A write to a register that does not exist must not restart the frame.
    write_reg(REG_UNMAPPED, CFG_DATA_W'($urandom));

    // Directed: dark frame with one bright centre; truncation in the divide shows,
    // the sender waits mid-frame for the core to catch up, and a pixel in the tail
    // acts as a drain tick.
    for (k = 0; k < 9; k++) begin
      if (k == 4) begin
        push_item(KIND_PIXEL, 8'd255, 8'd128, 8'd1);
        hold_until_caught_up();
      end else begin
        push_item(KIND_PIXEL, '0, '0, '0);
      end
    end
    push_item(KIND_PIXEL, '1, '1, '1);
    repeat (3) push_item(KIND_DRAIN, '1, '1, '1);

    // Random frames, mostly small and well formed. Sender idles lightly and the receiver
    // heavily first, then the other way round, then neither idles.
    stream_items = 0;
    while (stream_items < RANDOM_ITEMS) begin
      if (stream_items < RANDOM_ITEMS / 3) begin
        src_idle_pct = 6;
        sink_idle_pct = 84;
      end else if (stream_items < 2 * RANDOM_ITEMS / 3) begin
        src_idle_pct = 84;
        sink_idle_pct = 6;
      end else begin
        src_idle_pct = 0;
        sink_idle_pct = 0;
      end
      case ($urandom_range(0, 19))
        0: cols = $urandom_range(41, 64);
        1, 2, 3, 4: cols = $urandom_range(9, 40);
        default: cols = $urandom_range(1, 8);
      endcase
      rows = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 16) : $urandom_range(1, 8);
      set_frame(FW_W'(cols), FH_W'(rows));
      frames = $urandom_range(1, 3);
      for (f = 0; f < frames; f++) begin
        broken = (f == frames - 1) && ($urandom_range(0, 9) == 0);
        send_frame(cols, rows, $urandom_range(0, 6) == 0, broken);
      end
    end

    // Geometry extremes, run without idling: zero reads as one, oversized values
    // saturate to the maxima.
    src_idle_pct = 0;
    sink_idle_pct = 0;
    set_frame('0, '0);
    send_frame(1, 1, 1'b0, 1'b0);
    // An oversized width wraps at the line length: top-row results start one full line
    // and two pixels in; the next register write cuts the frame short.
    set_frame('1, FH_W'(3));
    for (k = 0; k < MAX_WIDTH + 5; k++)
      push_item(KIND_PIXEL, pick_level(), pick_level(), pick_level());
    set_frame(FW_W'(3), '1);
    send_frame(3, 8, 1'b1, 1'b1);
    set_frame(FW_W'(1), '1);
    send_frame(1, 8, 1'b0, 1'b1);
    set_frame(FW_W'(2), FH_W'(MAX_HEIGHT));
    send_frame(2, 4, 1'b0, 1'b1);

    // Let the tail drain, then allow a settling margin for anything unexpected.
    quiesce();
    if (tracker.blurred_q.size() != 0)
      $error("%0d blurred pixels never came out", tracker.blurred_q.size());
    if (tracker.mismatches == 0 && tracker.blurred_q.size() == 0)
      $display("PASS");
    else
      $display("FAIL");
    $finish;
  end

endmodule

[sim.f]
rtl/rbb3_pkg.sv
rtl/rbb3_if.sv
rtl/rbb3_ram.sv
rtl/rbb3_ctrl.sv
rtl/rbb3_window.sv
rtl/rbb3_out.sv
rtl/rgb_box_blur_3x3_core.sv
tb/tb_rgb_box_blur_3x3_core.sv
